// File: hw/rtl/fatcl_pkg.sv
// Shared types and constants for the FAT cluster entry locate/decode block.
// Depends on nothing; used by fatcl_calc and fat_cluster_entry_locate_decode_top.
`default_nettype none

package fatcl_pkg;

  // Table format codes.
  localparam logic [1:0] KIND_FAT12  = 2'd0;
  localparam logic [1:0] KIND_FAT16  = 2'd1;
  localparam logic [1:0] KIND_FAT32  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Action codes.
  localparam logic ACT_LOCATE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FAT_KIND      = 3'd0;
  localparam logic [2:0] REG_SECTOR_LOG2   = 3'd1;
  localparam logic [2:0] REG_CLUSTER_LOG2  = 3'd2;
  localparam logic [2:0] REG_RESERVED      = 3'd3;
  localparam logic [2:0] REG_HIDDEN        = 3'd4;
  localparam logic [2:0] REG_TABLE_COPIES  = 3'd5;
  localparam logic [2:0] REG_TABLE_SECTORS = 3'd6;
  localparam logic [2:0] REG_ROOT_AREA     = 3'd7;

  // Sector size limits (log2 of bytes).
  localparam logic [3:0] SECTOR_LOG2_MIN = 4'd9;
  localparam logic [3:0] SECTOR_LOG2_MAX = 4'd12;

  // Entry classification thresholds.
  localparam logic [27:0] ENTRY12_MASK = 28'h0000FFF;
  localparam logic [27:0] ENTRY32_MASK = 28'hFFFFFFF;
  localparam logic [27:0] EOC12        = 28'h0000FF8;
  localparam logic [27:0] EOC16        = 28'h000FFF8;
  localparam logic [27:0] EOC32        = 28'hFFFFFF8;
  localparam logic [27:0] BAD12        = 28'h0000FF7;
  localparam logic [27:0] BAD16        = 28'h000FFF7;
  localparam logic [27:0] BAD32        = 28'hFFFFFF7;

  // Configuration view seen by the datapath. data_base is the sum of
  // hidden, reserved, all FAT copies and the root area, kept in a register.
  typedef struct packed {
    logic [1:0]  fat_kind;
    logic [3:0]  sector_log2;
    logic [2:0]  cluster_log2;
    logic [15:0] reserved_count;
    logic [31:0] data_base;
  } cfg_t;

  // One accepted transaction.
  typedef struct packed {
    logic        action;
    logic [27:0] cluster;
    logic [15:0] sector_in_cluster;
    logic [31:0] raw_entry;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] table_sector;
    logic [11:0] table_byte_offset;
    logic [31:0] data_sector;
    logic        index_out_of_range;
    logic [27:0] next_cluster;
    logic        end_of_chain;
    logic        bad_cluster;
    logic        free_entry;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/fatcl_calc.sv
// Combinational locate and decode datapath for one transaction.
// Depends on fatcl_pkg for the configuration, item and result types.
`default_nettype none

module fatcl_calc (
  input  fatcl_pkg::cfg_t    cfg,
  input  fatcl_pkg::item_t   item,
  output fatcl_pkg::result_t res
);

  logic [3:0]  sl;
  logic [29:0] off;
  logic [29:0] off_shift;
  logic [11:0] off_mask;
  logic [31:0] rel;
  logic        idx_oor;
  logic [27:0] entry;
  logic        eoc;
  logic        bad;

  // Clamp the sector size to the supported range.
  always_comb begin
    if (cfg.sector_log2 < fatcl_pkg::SECTOR_LOG2_MIN) begin
      sl = fatcl_pkg::SECTOR_LOG2_MIN;
    end else if (cfg.sector_log2 > fatcl_pkg::SECTOR_LOG2_MAX) begin
      sl = fatcl_pkg::SECTOR_LOG2_MAX;
    end else begin
      sl = cfg.sector_log2;
    end
  end

  // Byte offset of the entry within the table.
  always_comb begin
    unique case (cfg.fat_kind)
      fatcl_pkg::KIND_FAT12: off = {2'b00, item.cluster} + {3'b000, item.cluster[27:1]};
      fatcl_pkg::KIND_FAT16: off = {1'b0, item.cluster, 1'b0};
      fatcl_pkg::KIND_FAT32: off = {item.cluster, 2'b00};
      default:               off = '0;
    endcase
  end

  assign off_shift = off >> sl;
  assign off_mask  = 12'((13'd1 << sl) - 13'd1);

  // Data sector mapping; the cluster offset wraps modulo 2^32.
  assign rel     = ({4'b0000, item.cluster} - 32'd2) << cfg.cluster_log2;
  assign idx_oor = (item.sector_in_cluster >> cfg.cluster_log2) != 16'd0;

  // Entry extraction and classification.
  always_comb begin
    unique case (cfg.fat_kind)
      fatcl_pkg::KIND_FAT12: begin
        if (item.cluster[0]) begin
          entry = {16'd0, item.raw_entry[15:4]};
        end else begin
          entry = {16'd0, item.raw_entry[11:0]};
        end
        eoc = entry >= fatcl_pkg::EOC12;
        bad = entry == fatcl_pkg::BAD12;
      end
      fatcl_pkg::KIND_FAT16: begin
        entry = {12'd0, item.raw_entry[15:0]};
        eoc   = entry >= fatcl_pkg::EOC16;
        bad   = entry == fatcl_pkg::BAD16;
      end
      fatcl_pkg::KIND_FAT32: begin
        entry = item.raw_entry[27:0] & fatcl_pkg::ENTRY32_MASK;
        eoc   = entry >= fatcl_pkg::EOC32;
        bad   = entry == fatcl_pkg::BAD32;
      end
      default: begin
        entry = '0;
        eoc   = 1'b1;
        bad   = 1'b0;
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (item.action == fatcl_pkg::ACT_LOCATE) begin
      res.table_sector      = {16'd0, cfg.reserved_count} + {2'b00, off_shift};
      res.table_byte_offset = off[11:0] & off_mask;
      res.index_out_of_range = idx_oor;
      if (!idx_oor) begin
        res.data_sector = cfg.data_base + rel + {16'd0, item.sector_in_cluster};
      end
    end else begin
      res.next_cluster = entry;
      res.end_of_chain = eoc;
      res.bad_cluster  = bad;
      res.free_entry   = entry == 28'd0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fat_cluster_entry_locate_decode_top.sv
// Top level of the FAT cluster entry locate/decode block: APB registers,
// input and result registers. Depends on fatcl_pkg and fatcl_calc.
//
//   Channel   Direction  Handshake             Payload
//   --------  ---------  --------------------  ----------------------------------------
//   input     in         start & !busy         in_action, in_cluster,
//                                              in_sector_in_cluster, in_raw_entry
//   result    out        out_valid (1 cycle)   out_table_sector ... out_free_entry
//   config    in/out     psel&penable&pwrite   paddr, pwdata, prdata, pready
//
// Every transaction passes through the input register, then through the datapath
// into the result register. A new transaction may be accepted every cycle while
// busy is low, so throughput is one per cycle. The receiver cannot stall; each
// result is shown for exactly one cycle. busy rises during an APB write access
// and in the cycle after it, while the precomputed data base (FAT copies times
// table size plus the fixed offsets) settles through its multiply and add
// registers. Reset is synchronous and active low and restores the register
// defaults.
`default_nettype none

module fat_cluster_entry_locate_decode_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [27:0] in_cluster,
  input  wire logic [15:0] in_sector_in_cluster,
  input  wire logic [31:0] in_raw_entry,

  output logic             out_valid,
  output logic [31:0]      out_table_sector,
  output logic [11:0]      out_table_byte_offset,
  output logic [31:0]      out_data_sector,
  output logic             out_index_out_of_range,
  output logic [27:0]      out_next_cluster,
  output logic             out_end_of_chain,
  output logic             out_bad_cluster,
  output logic             out_free_entry,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic [1:0]  fat_kind_r;
  logic [3:0]  sector_log2_r;
  logic [2:0]  cluster_log2_r;
  logic [15:0] reserved_r;
  logic [31:0] hidden_r;
  logic [7:0]  copies_r;
  logic [31:0] table_sectors_r;
  logic [15:0] root_area_r;

  // Derived base: product registered in fats_r, then the sum in base_r.
  logic [31:0] fats_r;
  logic [31:0] base_r;
  logic [39:0] fats_full;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        cfg_settle_r;

  logic        accept;
  logic        item_valid_r;
  fatcl_pkg::item_t   item_r;
  fatcl_pkg::cfg_t    cfg_view;
  fatcl_pkg::result_t res_nxt;
  fatcl_pkg::result_t res_r;
  logic        res_valid_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_kind_r      <= fatcl_pkg::KIND_FAT12;
      sector_log2_r   <= 4'd9;
      cluster_log2_r  <= 3'd0;
      reserved_r      <= 16'd1;
      hidden_r        <= 32'd0;
      copies_r        <= 8'd2;
      table_sectors_r <= 32'd0;
      root_area_r     <= 16'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fatcl_pkg::REG_FAT_KIND:      fat_kind_r      <= pwdata[1:0];
        fatcl_pkg::REG_SECTOR_LOG2:   sector_log2_r   <= pwdata[3:0];
        fatcl_pkg::REG_CLUSTER_LOG2:  cluster_log2_r  <= pwdata[2:0];
        fatcl_pkg::REG_RESERVED:      reserved_r      <= pwdata[15:0];
        fatcl_pkg::REG_HIDDEN:        hidden_r        <= pwdata;
        fatcl_pkg::REG_TABLE_COPIES:  copies_r        <= pwdata[7:0];
        fatcl_pkg::REG_TABLE_SECTORS: table_sectors_r <= pwdata;
        fatcl_pkg::REG_ROOT_AREA:     root_area_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      fatcl_pkg::REG_FAT_KIND:      prdata = {30'd0, fat_kind_r};
      fatcl_pkg::REG_SECTOR_LOG2:   prdata = {28'd0, sector_log2_r};
      fatcl_pkg::REG_CLUSTER_LOG2:  prdata = {29'd0, cluster_log2_r};
      fatcl_pkg::REG_RESERVED:      prdata = {16'd0, reserved_r};
      fatcl_pkg::REG_HIDDEN:        prdata = hidden_r;
      fatcl_pkg::REG_TABLE_COPIES:  prdata = {24'd0, copies_r};
      fatcl_pkg::REG_TABLE_SECTORS: prdata = table_sectors_r;
      fatcl_pkg::REG_ROOT_AREA:     prdata = {16'd0, root_area_r};
      default:                      prdata = '0;
    endcase
  end

  // The data base only changes after a register write, so it is computed
  // off the critical path: the product is registered in fats_r and then the sum
  // in base_r, before any new transaction can reach the datapath.
  assign fats_full = {32'd0, copies_r} * {8'd0, table_sectors_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fats_r       <= 32'd0;
      base_r       <= 32'd1;
      cfg_settle_r <= 1'b0;
    end else begin
      fats_r       <= fats_full[31:0];
      base_r       <= hidden_r + {16'd0, reserved_r} + fats_r + {16'd0, root_area_r};
      cfg_settle_r <= cfg_wr;
    end
  end

  assign busy   = cfg_wr | cfg_settle_r;
  assign accept = start & ~busy;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action            <= in_action;
      item_r.cluster           <= in_cluster;
      item_r.sector_in_cluster <= in_sector_in_cluster;
      item_r.raw_entry         <= in_raw_entry;
    end
  end

  assign cfg_view.fat_kind       = fat_kind_r;
  assign cfg_view.sector_log2    = sector_log2_r;
  assign cfg_view.cluster_log2   = cluster_log2_r;
  assign cfg_view.reserved_count = reserved_r;
  assign cfg_view.data_base      = base_r;

  fatcl_calc u_calc (
    .cfg  (cfg_view),
    .item (item_r),
    .res  (res_nxt)
  );

  // Result register; each result is strobed for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = res_valid_r;
  assign out_table_sector       = res_r.table_sector;
  assign out_table_byte_offset  = res_r.table_byte_offset;
  assign out_data_sector        = res_r.data_sector;
  assign out_index_out_of_range = res_r.index_out_of_range;
  assign out_next_cluster       = res_r.next_cluster;
  assign out_end_of_chain       = res_r.end_of_chain;
  assign out_bad_cluster        = res_r.bad_cluster;
  assign out_free_entry         = res_r.free_entry;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for fat_cluster_entry_locate_decode_top: directed rows, then random
// transactions over several register settings, each checked against a local predictor.
// Depends on fatcl_pkg and the RTL of the block; needs no files or arguments.

module testbench;

  // The limit is far above the slowest correct run (about 1050 transactions, each followed by
  // at most one gap, plus register writes and drains).
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 129;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel.
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [27:0] in_cluster = '0;
  logic [15:0] in_sector_in_cluster = '0;
  logic [31:0] in_raw_entry = '0;

  // Result channel; the block shows each result for one cycle and cannot be stalled.
  logic        out_valid;
  logic [31:0] out_table_sector;
  logic [11:0] out_table_byte_offset;
  logic [31:0] out_data_sector;
  logic        out_index_out_of_range;
  logic [27:0] out_next_cluster;
  logic        out_end_of_chain;
  logic        out_bad_cluster;
  logic        out_free_entry;

  // APB register port. pready is always high, prdata is not checked here.
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fat_cluster_entry_locate_decode_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_action              (in_action),
    .in_cluster             (in_cluster),
    .in_sector_in_cluster   (in_sector_in_cluster),
    .in_raw_entry           (in_raw_entry),
    .out_valid              (out_valid),
    .out_table_sector       (out_table_sector),
    .out_table_byte_offset  (out_table_byte_offset),
    .out_data_sector        (out_data_sector),
    .out_index_out_of_range (out_index_out_of_range),
    .out_next_cluster       (out_next_cluster),
    .out_end_of_chain       (out_end_of_chain),
    .out_bad_cluster        (out_bad_cluster),
    .out_free_entry         (out_free_entry),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, starting from the reset defaults. It is only changed
  // while nothing is in flight, so every transaction sees one consistent setting.
  logic [1:0]  vol_kind = fatcl_pkg::KIND_FAT12;
  logic [3:0]  vol_sector_log2 = 4'd9;
  logic [2:0]  vol_cluster_log2 = 3'd0;
  logic [15:0] vol_reserved = 16'd1;
  logic [31:0] vol_hidden = '0;
  logic [7:0]  vol_copies = 8'd2;
  logic [31:0] vol_table_sectors = '0;
  logic [15:0] vol_root_area = '0;

  // Results still owed by the block, oldest first.
  fatcl_pkg::result_t pending_results[$];

  int cycle_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int setting_count = 0;
  int oor_count = 0;
  int eoc_count = 0;
  int bad_count = 0;
  int free_count = 0;

  // One row of the directed part: either a register write or a transaction. A transaction
  // whose result is obvious from the reset setting or from an extreme carries it typed in;
  // the others are predicted.
  typedef struct {
    bit                 is_cfg;
    logic [2:0]         reg_idx;
    logic [31:0]        reg_val;
    fatcl_pkg::item_t   txn;
    bit                 typed;
    fatcl_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // Predicts the single result of one transaction under the current shadow registers.
  function automatic fatcl_pkg::result_t predict_entry(fatcl_pkg::item_t txn);
    fatcl_pkg::result_t r;
    logic [3:0]  sl;
    logic [31:0] clu32;
    logic [31:0] offset;
    logic [31:0] span;
    logic [63:0] fat_area;
    logic [31:0] rel;
    logic [27:0] e;
    r = '0;
    clu32 = {4'b0, txn.cluster};
    if (txn.action == fatcl_pkg::ACT_LOCATE) begin
      sl = vol_sector_log2;
      if (sl < fatcl_pkg::SECTOR_LOG2_MIN) sl = fatcl_pkg::SECTOR_LOG2_MIN;
      if (sl > fatcl_pkg::SECTOR_LOG2_MAX) sl = fatcl_pkg::SECTOR_LOG2_MAX;
      // Byte offset of the entry within one table copy: 1.5, 2 or 4 bytes per cluster.
      case (vol_kind)
        fatcl_pkg::KIND_FAT12: offset = clu32 + (clu32 >> 1);
        fatcl_pkg::KIND_FAT16: offset = clu32 << 1;
        fatcl_pkg::KIND_FAT32: offset = clu32 << 2;
        default: offset = '0;
      endcase
      span = (32'd1 << sl) - 32'd1;
      r.table_sector = {16'b0, vol_reserved} + (offset >> sl);
      r.table_byte_offset = offset[11:0] & span[11:0];
      if ({1'b0, txn.sector_in_cluster} >= (17'd1 << vol_cluster_log2)) begin
        r.index_out_of_range = 1'b1;
      end else begin
        fat_area = {56'b0, vol_copies} * {32'b0, vol_table_sectors};
        // Clusters below two wrap around, like every other term of the sum.
        rel = (clu32 - 32'd2) << vol_cluster_log2;
        r.data_sector = vol_hidden + {16'b0, vol_reserved} + fat_area[31:0]
                      + {16'b0, vol_root_area} + rel + {16'b0, txn.sector_in_cluster};
      end
    end else begin
      case (vol_kind)
        fatcl_pkg::KIND_FAT12: begin
          // Odd clusters sit in the upper 12 bits of the 16-bit word, even ones in the lower.
          e = txn.cluster[0] ? {16'b0, txn.raw_entry[15:4]} : {16'b0, txn.raw_entry[11:0]};
          r.end_of_chain = (e >= fatcl_pkg::EOC12);
          r.bad_cluster = (e == fatcl_pkg::BAD12);
        end
        fatcl_pkg::KIND_FAT16: begin
          e = {12'b0, txn.raw_entry[15:0]};
          r.end_of_chain = (e >= fatcl_pkg::EOC16);
          r.bad_cluster = (e == fatcl_pkg::BAD16);
        end
        fatcl_pkg::KIND_FAT32: begin
          e = txn.raw_entry[27:0];
          r.end_of_chain = (e >= fatcl_pkg::EOC32);
          r.bad_cluster = (e == fatcl_pkg::BAD32);
        end
        default: begin
          e = '0;
          r.end_of_chain = 1'b1;
          r.bad_cluster = 1'b0;
        end
      endcase
      r.next_cluster = e;
      r.free_entry = (e == '0);
    end
    return r;
  endfunction

  function automatic fatcl_pkg::item_t make_item(logic act, logic [27:0] clu, logic [15:0] idx,
                                                 logic [31:0] raw);
    fatcl_pkg::item_t t;
    t.action = act;
    t.cluster = clu;
    t.sector_in_cluster = idx;
    t.raw_entry = raw;
    return t;
  endfunction

  // Typed expectations: a locate result leaves the decode fields zero and the other way round.
  function automatic fatcl_pkg::result_t locate_result(logic [31:0] ts, logic [11:0] bo,
                                                       logic [31:0] ds, logic oor);
    fatcl_pkg::result_t r;
    r = '0;
    r.table_sector = ts;
    r.table_byte_offset = bo;
    r.data_sector = ds;
    r.index_out_of_range = oor;
    return r;
  endfunction

  function automatic fatcl_pkg::result_t decode_result(logic [27:0] nc, logic eoc, logic bad,
                                                       logic fr);
    fatcl_pkg::result_t r;
    r = '0;
    r.next_cluster = nc;
    r.end_of_chain = eoc;
    r.bad_cluster = bad;
    r.free_entry = fr;
    return r;
  endfunction

  task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endtask

  task automatic add_txn(fatcl_pkg::item_t txn, bit typed, fatcl_pkg::result_t want);
    dir_row_t row;
    row = '{default: '0};
    row.txn = txn;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Offers one transaction and returns at the edge that accepts it. start is left high, so
  // the caller either offers the next one at once or lowers start for a gap.
  task automatic send_transaction(fatcl_pkg::item_t txn, bit typed, fatcl_pkg::result_t want);
    fatcl_pkg::result_t r;
    start <= 1'b1;
    in_action <= txn.action;
    in_cluster <= txn.cluster;
    in_sector_in_cluster <= txn.sector_in_cluster;
    in_raw_entry <= txn.raw_entry;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = typed ? want : predict_entry(txn);
    pending_results.push_back(r);
    sent_count++;
    if (r.index_out_of_range) oor_count++;
    if (r.end_of_chain) eoc_count++;
    if (r.bad_cluster) bad_count++;
    if (r.free_entry) free_count++;
  endtask

  task automatic idle_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic settle_all();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // APB write: setup cycle, access cycle, then an idle cycle so that the next write starts
  // in a later time step. The shadow copy keeps only the register's own bits.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fatcl_pkg::REG_FAT_KIND:      vol_kind = value[1:0];
      fatcl_pkg::REG_SECTOR_LOG2:   vol_sector_log2 = value[3:0];
      fatcl_pkg::REG_CLUSTER_LOG2:  vol_cluster_log2 = value[2:0];
      fatcl_pkg::REG_RESERVED:      vol_reserved = value[15:0];
      fatcl_pkg::REG_HIDDEN:        vol_hidden = value;
      fatcl_pkg::REG_TABLE_COPIES:  vol_copies = value[7:0];
      fatcl_pkg::REG_TABLE_SECTORS: vol_table_sectors = value;
      fatcl_pkg::REG_ROOT_AREA:     vol_root_area = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // A count for a register of the given width: zero, all ones, small, or anything.
  function automatic logic [31:0] pick_count(int width);
    logic [31:0] ones;
    ones = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ones;
      2, 3: return $urandom_range(0, 64) & ones;
      default: return $urandom() & ones;
    endcase
  endfunction

  // Sets stray bits above a narrow register's width now and then; the block must drop them.
  function automatic logic [31:0] with_stray(logic [31:0] value, int width, bit allow);
    if (allow && width < 32 && $urandom_range(0, 3) == 0) return value | ($urandom() << width);
    return value;
  endfunction

  // Phase 0 holds every register at its minimum, phase 1 at its maximum; the rest are random
  // with the table kind cycling through all four codes and the sector size sometimes outside
  // the supported range.
  task automatic program_phase(int p);
    bit lo;
    bit hi;
    bit rnd;
    logic [31:0] v;
    lo = (p == 0);
    hi = (p == 1);
    rnd = !lo && !hi;
    settle_all();
    v = hi ? {30'b0, fatcl_pkg::KIND_FAT32} : {30'b0, p[1:0]};
    write_reg(fatcl_pkg::REG_FAT_KIND, with_stray(v, 2, rnd));
    if (lo) v = 32'd9;
    else if (hi) v = 32'd12;
    else if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 15);
    else v = $urandom_range(9, 12);
    write_reg(fatcl_pkg::REG_SECTOR_LOG2, with_stray(v, 4, rnd));
    v = lo ? 32'd0 : (hi ? 32'd7 : $urandom_range(0, 7));
    write_reg(fatcl_pkg::REG_CLUSTER_LOG2, with_stray(v, 3, rnd));
    v = lo ? 32'd0 : (hi ? 32'hFFFF : pick_count(16));
    write_reg(fatcl_pkg::REG_RESERVED, with_stray(v, 16, rnd));
    v = lo ? 32'd0 : (hi ? 32'hFFFF_FFFF : pick_count(32));
    write_reg(fatcl_pkg::REG_HIDDEN, v);
    v = lo ? 32'd0 : (hi ? 32'hFF : pick_count(8));
    write_reg(fatcl_pkg::REG_TABLE_COPIES, with_stray(v, 8, rnd));
    v = lo ? 32'd0 : (hi ? 32'hFFFF_FFFF : pick_count(32));
    write_reg(fatcl_pkg::REG_TABLE_SECTORS, v);
    v = lo ? 32'd0 : (hi ? 32'hFFFF : pick_count(16));
    write_reg(fatcl_pkg::REG_ROOT_AREA, with_stray(v, 16, rnd));
    setting_count++;
  endtask

  // Random transaction. Clusters lean toward the low end and the top of the range, sector
  // indexes mostly fall inside the cluster, and raw words often carry a free, bad or
  // end-of-chain entry placed where the current table kind reads it.
  task automatic random_item(output fatcl_pkg::item_t txn);
    int          per_cluster;
    logic [27:0] clu;
    logic [15:0] idx;
    logic [31:0] raw;
    logic [27:0] e;
    logic [27:0] bad_e;
    logic [27:0] eoc_e;
    int          pick;
    per_cluster = 1 << vol_cluster_log2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: clu = 28'($urandom_range(0, 17));
      4: clu = 28'(28'hFFF_FFFF - $urandom_range(0, 15));
      default: clu = 28'($urandom());
    endcase
    case ($urandom_range(0, 9))
      7: idx = 16'(per_cluster);
      8: idx = 16'($urandom());
      9: idx = 16'hFFFF;
      default: idx = 16'($urandom_range(0, per_cluster - 1));
    endcase
    raw = $urandom();
    pick = $urandom_range(0, 4);
    case (vol_kind)
      fatcl_pkg::KIND_FAT12: begin
        bad_e = fatcl_pkg::BAD12;
        eoc_e = fatcl_pkg::EOC12;
      end
      fatcl_pkg::KIND_FAT16: begin
        bad_e = fatcl_pkg::BAD16;
        eoc_e = fatcl_pkg::EOC16;
      end
      default: begin
        bad_e = fatcl_pkg::BAD32;
        eoc_e = fatcl_pkg::EOC32;
      end
    endcase
    e = (pick == 0) ? '0 : (pick == 1) ? bad_e : 28'(eoc_e + $urandom_range(0, 7));
    if (pick <= 2) begin
      case (vol_kind)
        fatcl_pkg::KIND_FAT12: begin
          if (clu[0]) raw[15:4] = e[11:0];
          else raw[11:0] = e[11:0];
        end
        fatcl_pkg::KIND_FAT16: raw[15:0] = e[15:0];
        default: raw[27:0] = e;
      endcase
    end
    txn = make_item(logic'($urandom_range(0, 1)), clu, idx, raw);
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      // Keep the log short if something is broken everywhere.
      if (mismatch_count <= 40) $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  // Result checker: each strobe is matched against the oldest owed result, field by field.
  always @(posedge clk) begin : check_results
    fatcl_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result transaction with none outstanding");
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        report_field("table_sector", want.table_sector, out_table_sector);
        report_field("table_byte_offset", 32'(want.table_byte_offset),
                     32'(out_table_byte_offset));
        report_field("data_sector", want.data_sector, out_data_sector);
        report_field("index_out_of_range", 32'(want.index_out_of_range),
                     32'(out_index_out_of_range));
        report_field("next_cluster", 32'(want.next_cluster), 32'(out_next_cluster));
        report_field("end_of_chain", 32'(want.end_of_chain), 32'(out_end_of_chain));
        report_field("bad_cluster", 32'(want.bad_cluster), 32'(out_bad_cluster));
        report_field("free_entry", 32'(want.free_entry), 32'(out_free_entry));
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    fatcl_pkg::item_t txn;
    bit               idle_on;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first rows run on the reset setting (FAT12, 512-byte sectors, one
    // sector per cluster, one reserved sector, two empty table copies), so their results
    // can be written down directly.
    // Cluster zero: the data sector wraps below zero.
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd0, 16'd0, 32'h0), 1'b1,
            locate_result(32'd1, 12'd0, 32'hFFFF_FFFF, 1'b0));
    // Cluster one wraps the other way and lands exactly on sector zero.
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd1, 16'd0, 32'hFFFF_FFFF), 1'b1,
            locate_result(32'd1, 12'd1, 32'd0, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd2, 16'd0, 32'h0), 1'b1,
            locate_result(32'd1, 12'd3, 32'd1, 1'b0));
    // Sector index one is already past a one-sector cluster.
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd3, 16'd1, 32'h0), 1'b1,
            locate_result(32'd1, 12'd4, 32'd0, 1'b1));
    // Largest cluster and index: offset 0x17FFFFFE bytes.
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'hFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
            locate_result(32'h000C_0000, 12'h1FE, 32'd0, 1'b1));
    // FAT12 decode: even clusters read the low 12 bits, odd ones bits 15..4.
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd4, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
            decode_result(28'hFFF, 1'b1, 1'b0, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd5, 16'd0, 32'h0000_FF70), 1'b1,
            decode_result(28'hFF7, 1'b0, 1'b1, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd6, 16'd0, 32'hFFFF_F000), 1'b1,
            decode_result(28'h0, 1'b0, 1'b0, 1'b1));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd7, 16'd0, 32'h1234_5678), 1'b1,
            decode_result(28'h567, 1'b0, 1'b0, 1'b0));

    // FAT16 with the sector size above range (clamped to 4096) and 128-sector clusters.
    add_cfg(fatcl_pkg::REG_FAT_KIND, {30'b0, fatcl_pkg::KIND_FAT16});
    add_cfg(fatcl_pkg::REG_SECTOR_LOG2, 32'd15);
    add_cfg(fatcl_pkg::REG_CLUSTER_LOG2, 32'd7);
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd0, 16'd0, 32'hFFFF_FFF8), 1'b1,
            decode_result(28'hFFF8, 1'b1, 1'b0, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd1, 16'd0, 32'h0000_FFF7), 1'b1,
            decode_result(28'hFFF7, 1'b0, 1'b1, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd2, 16'd0, 32'hABCD_0000), 1'b1,
            decode_result(28'h0, 1'b0, 1'b0, 1'b1));
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'hFFF_FFFF, 16'd127, 32'h0), 1'b0, '0);
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd2, 16'd128, 32'h0), 1'b0, '0);

    // FAT32 with every count at its maximum and the sector size below range.
    add_cfg(fatcl_pkg::REG_FAT_KIND, {30'b0, fatcl_pkg::KIND_FAT32});
    add_cfg(fatcl_pkg::REG_SECTOR_LOG2, 32'd0);
    add_cfg(fatcl_pkg::REG_RESERVED, 32'hFFFF);
    add_cfg(fatcl_pkg::REG_HIDDEN, 32'hFFFF_FFFF);
    add_cfg(fatcl_pkg::REG_TABLE_COPIES, 32'hFF);
    add_cfg(fatcl_pkg::REG_TABLE_SECTORS, 32'hFFFF_FFFF);
    add_cfg(fatcl_pkg::REG_ROOT_AREA, 32'hFFFF);
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd9, 16'd0, 32'hFFFF_FFFF), 1'b1,
            decode_result(28'hFFF_FFFF, 1'b1, 1'b0, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd9, 16'd0, 32'hF000_0000), 1'b1,
            decode_result(28'h0, 1'b0, 1'b0, 1'b1));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd9, 16'd0, 32'h0FFF_FFF7), 1'b1,
            decode_result(28'hFFF_FFF7, 1'b0, 1'b1, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd9, 16'd0, 32'h0FFF_FFF6), 1'b1,
            decode_result(28'hFFF_FFF6, 1'b0, 1'b0, 1'b0));
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'hFFF_FFFF, 16'd0, 32'h0), 1'b0, '0);
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd0, 16'd127, 32'h0), 1'b0, '0);

    // The unused table kind: no entry, always end of chain and free.
    add_cfg(fatcl_pkg::REG_FAT_KIND, {30'b0, fatcl_pkg::KIND_UNUSED});
    add_txn(make_item(fatcl_pkg::ACT_DECODE, 28'd3, 16'd0, 32'h1234_5678), 1'b1,
            decode_result(28'h0, 1'b1, 1'b0, 1'b1));
    add_txn(make_item(fatcl_pkg::ACT_LOCATE, 28'd12345, 16'd5, 32'h0), 1'b0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle_all();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_transaction(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part. Within a phase the sender alternates between stretches with bursty gaps
    // and stretches at full rate; now and then it waits for every result before going on.
    // The last phase runs back to back without any gaps.
    idle_on = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      program_phase(p);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
        random_item(txn);
        send_transaction(txn, 1'b0, '0);
        if (p != PHASES - 1) begin
          if (idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 13));
          else if ($urandom_range(0, 79) == 0) settle_all();
        end
      end
    end

    // Wait for the last results, then keep the checker running to catch any stray strobe.
    settle_all();
    repeat (4) @(posedge clk);

    $display("Checked %0d results of %0d transactions over %0d random register settings.",
             checked_count, sent_count, setting_count);
    $display("Expected corner results: %0d index out of range, %0d end of chain,",
             oor_count, eoc_count);
    $display("  %0d bad, %0d free.", bad_count, free_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/fatcl_pkg.sv
hw/rtl/fatcl_calc.sv
hw/rtl/fat_cluster_entry_locate_decode_top.sv
tb/testbench.sv
